// ===== rtl/keypad_segment_display_refresher_top_macros.svh =====
// assertion macros for the keypad segment display refresher
// used by keypad_segment_display_refresher_top only, no other dependencies
`ifndef KEYPAD_SEGMENT_DISPLAY_REFRESHER_TOP_MACROS_SVH
`define KEYPAD_SEGMENT_DISPLAY_REFRESHER_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define KSDR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ksdr assertion failed");

// next-cycle implication, checked outside reset
`define KSDR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ksdr assertion failed");

`endif

// ===== rtl/ksdr_pkg.sv =====
// shared constants and glyph lookup for the keypad segment display refresher
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ksdr_pkg;

    localparam int unsigned WORD_W    = 16;
    localparam int unsigned FRAME_W   = 36;
    localparam int unsigned CURSOR_W  = 3;
    localparam int unsigned N_ENTRIES = 5;

    localparam logic [7:0] KEY_BACKSPACE = 8'h08;
    localparam logic [7:0] KEY_TAB       = 8'h09;
    localparam logic [7:0] KEY_SPACE     = 8'h20;
    localparam logic [7:0] KEY_DIGIT_LO  = 8'h30;
    localparam logic [7:0] KEY_DIGIT_HI  = 8'h39;
    localparam logic [7:0] KEY_HEX_LO    = 8'h61;
    localparam logic [7:0] KEY_HEX_HI    = 8'h66;

    localparam logic [CURSOR_W-1:0] NPOS_SMALL = 3'd5;
    localparam logic [CURSOR_W-1:0] NPOS_BIG   = 3'd4;

    typedef logic [WORD_W-1:0]  t_word;
    typedef logic [FRAME_W-1:0] t_frame;

    // segment code for one hex digit in the given display mode
    function automatic t_word glyph(input logic wide, input logic [3:0] d);
        t_word g;
        if (!wide) begin
            unique case (d)
                4'h0: g = 16'h003F;
                4'h1: g = 16'h0006;
                4'h2: g = 16'h005B;
                4'h3: g = 16'h004F;
                4'h4: g = 16'h0066;
                4'h5: g = 16'h006D;
                4'h6: g = 16'h007D;
                4'h7: g = 16'h0007;
                4'h8: g = 16'h007F;
                4'h9: g = 16'h006F;
                4'hA: g = 16'h0077;
                4'hB: g = 16'h007C;
                4'hC: g = 16'h0039;
                4'hD: g = 16'h005E;
                4'hE: g = 16'h0079;
                4'hF: g = 16'h0071;
            endcase
        end else begin
            unique case (d)
                4'h0: g = 16'h003F;
                4'h1: g = 16'h0086;
                4'h2: g = 16'h111B;
                4'h3: g = 16'h010F;
                4'h4: g = 16'h1126;
                4'h5: g = 16'h112D;
                4'h6: g = 16'h113D;
                4'h7: g = 16'h0481;
                4'h8: g = 16'h113F;
                4'h9: g = 16'h1127;
                4'hA: g = 16'h1137;
                4'hB: g = 16'h054F;
                4'hC: g = 16'h0039;
                4'hD: g = 16'h044F;
                4'hE: g = 16'h1139;
                4'hF: g = 16'h1131;
            endcase
        end
        return g;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/keypad_segment_display_refresher_top.sv =====
// keypad segment display refresher: key edits, cursor, mode and frame build
// depends on ksdr_pkg and keypad_segment_display_refresher_top_macros.svh
`timescale 1ns / 1ps
`default_nettype none
// usage
//   key channel: i_key_valid / o_key_ready carry one ascii key code a beat
//   frame channel: o_frame_valid / i_frame_ready carry 36-bit shift frames,
//   bit 0 shifted first, o_last marks the final frame of a refresh
//   a key updates the segment words, cursor and mode in the cycle it is taken;
//   the refresh frames built from the updated state appear in the output
//   register on the next cycle
//   7-segment mode gives one frame a key, so while i_frame_ready is high
//   a key can be taken every cycle; 16-segment mode gives two multiplexed
//   frames; the second waits in a holding register and holds off new keys
//   the key port is ready whenever the output register is empty or is being
//   emptied this cycle with nothing left behind it; a stall on the frame side
//   holds both frames and stops new keys, nothing is dropped
//   reset (synchronous, active low) blanks all words, sets the cursor to 0,
//   selects 7-segment mode and empties the output

`include "keypad_segment_display_refresher_top_macros.svh"

module keypad_segment_display_refresher_top
    import ksdr_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_key_valid,
    output logic              o_key_ready,
    input  wire logic [7:0]   i_key_code,
    output logic              o_frame_valid,
    input  wire logic         i_frame_ready,
    output logic [FRAME_W-1:0] o_frame,
    output logic              o_last
);

    // display state
    t_word                 r_words [N_ENTRIES];
    logic [CURSOR_W-1:0]   r_cursor;
    logic                  r_wide;

    // output register and holding register for the second wide frame
    logic                  r_valid;
    t_frame                r_frame;
    logic                  r_last;
    logic                  r_has2;
    t_frame                r_frame2;

    t_word                 n_words [N_ENTRIES];
    logic [CURSOR_W-1:0]   n_cursor;
    logic                  n_wide;

    logic                  key_take;
    logic                  frame_take;
    logic                  is_digit;
    logic                  is_hex;
    logic [3:0]            digit;
    logic [CURSOR_W-1:0]   npos;
    logic [CURSOR_W-1:0]   npos_new;
    logic [CURSOR_W-1:0]   cur;
    logic [CURSOR_W-1:0]   cur_next;
    logic                  wr_en;
    logic [CURSOR_W-1:0]   wr_idx;
    t_word                 wr_data;
    t_frame                frame_a;
    t_frame                frame_b;

    assign frame_take  = r_valid && i_frame_ready;
    assign o_key_ready = !r_valid || (i_frame_ready && !r_has2);
    assign key_take    = i_key_valid && o_key_ready;

    // key decode
    assign is_digit = (i_key_code >= KEY_DIGIT_LO) && (i_key_code <= KEY_DIGIT_HI);
    assign is_hex   = (i_key_code >= KEY_HEX_LO) && (i_key_code <= KEY_HEX_HI);
    // 'a' has low nibble 1, so adding 9 gives 10
    assign digit    = is_hex ? (i_key_code[3:0] + 4'd9) : i_key_code[3:0];

    assign npos = r_wide ? NPOS_BIG : NPOS_SMALL;
    // cursor is kept in range, the wrap only guards the impossible case
    assign cur  = (r_cursor >= npos) ? '0 : r_cursor;

    always_comb begin
        wr_en    = 1'b0;
        wr_idx   = cur;
        wr_data  = '0;
        cur_next = cur;
        n_wide   = r_wide;
        priority if (is_digit || is_hex || (i_key_code == KEY_SPACE)) begin
            wr_en    = 1'b1;
            wr_data  = (is_digit || is_hex) ? glyph(r_wide, digit) : '0;
            cur_next = cur + 3'd1;
        end else if (i_key_code == KEY_BACKSPACE) begin
            // step back with wrap from position 0 to the last position
            cur_next = ((cur == '0) ? npos : cur) - 3'd1;
            wr_en    = 1'b1;
            wr_idx   = cur_next;
        end else if (i_key_code == KEY_TAB) begin
            n_wide   = !r_wide;
            cur_next = '0;
        end else begin
            // refresh only
        end
    end

    assign npos_new = n_wide ? NPOS_BIG : NPOS_SMALL;
    assign n_cursor = (cur_next >= npos_new) ? '0 : cur_next;

    always_comb begin
        for (int i = 0; i < N_ENTRIES; i++) begin
            n_words[i] = (wr_en && (wr_idx == CURSOR_W'(i))) ? wr_data : r_words[i];
        end
    end

    // frames from the updated words
    // 7-segment: start bit then the low 7 bits of entries 0..4
    // 16-segment frame a: entries 0 and 2, select bits 1,0, filler at level 0
    // 16-segment frame b: entries 1 and 3, select bits 0,1, filler at level 1
    always_comb begin
        if (!n_wide) begin
            frame_a = {n_words[4][6:0], n_words[3][6:0], n_words[2][6:0],
                       n_words[1][6:0], n_words[0][6:0], 1'b1};
        end else begin
            frame_a = {3'b000, 1'b0, 1'b1, n_words[2][14:0], n_words[0][14:0], 1'b1};
        end
        frame_b = {3'b111, 1'b1, 1'b0, n_words[3][14:0], n_words[1][14:0], 1'b1};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N_ENTRIES; i++) begin
                r_words[i] <= '0;
            end
            r_cursor <= '0;
            r_wide   <= 1'b0;
            r_valid  <= 1'b0;
            r_has2   <= 1'b0;
        end else begin
            if (key_take) begin
                r_words  <= n_words;
                r_cursor <= n_cursor;
                r_wide   <= n_wide;
                r_valid  <= 1'b1;
                r_has2   <= n_wide;
            end else if (frame_take) begin
                r_valid  <= r_has2;
                r_has2   <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (key_take) begin
            r_frame  <= frame_a;
            r_last   <= !n_wide;
            r_frame2 <= frame_b;
        end else if (frame_take && r_has2) begin
            r_frame  <= r_frame2;
            r_last   <= 1'b1;
        end
    end

    assign o_frame_valid = r_valid;
    assign o_frame       = r_frame;
    assign o_last        = r_last;

    // checks
    `KSDR_ASSERT_NOW(a_has2_needs_valid, i_clk, i_rst_n, r_has2, r_valid && !r_last)
    `KSDR_ASSERT_NOW(a_start_bit, i_clk, i_rst_n, r_valid, r_frame[0])
    `KSDR_ASSERT_NOW(a_cursor_range, i_clk, i_rst_n, 1'b1,
        (r_wide && (r_cursor < NPOS_BIG)) || (!r_wide && (r_cursor < NPOS_SMALL)))
    `KSDR_ASSERT_NEXT(a_second_frame, i_clk, i_rst_n, frame_take && r_has2,
        r_valid && r_last && !r_has2)

endmodule

`default_nettype wire
